// ----- src/sgpg_pkg.sv -----
// Shared types and constants of the sine grating pixel generator.
package sgpg_pkg;

  // Payload and register widths.
  localparam int CoordW  = 8;
  localparam int CfgW    = 4;
  localparam int CfgIdxW = 2;
  localparam int OutW    = 16;
  localparam int SinW    = 16;

  // Grating arithmetic constants.
  localparam int BasePeriod = 256;
  localparam int OneHalfQ15 = 16384;
  localparam int OneQ15     = 32768;

  // Amplitude scaling: floor((|n| + 20) / 40) is done as a shift by 3 and a divide by 5.
  localparam int RoundBias    = 20;
  localparam int AmpDivShift  = 3;
  localparam int DivFive      = 5;
  localparam int DivFiveShift = 20;
  localparam int DivFiveRecip = 209715;

  // Pipeline depth: the whole datapath and the part that runs per coordinate.
  localparam int NumStages  = 10;
  localparam int LaneStages = 7;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_AMPLITUDE = 2'd0,
    CFG_HFREQ     = 2'd1,
    CFG_VFREQ     = 2'd2,
    CFG_STRETCH   = 2'd3
  } cfg_reg_e;

endpackage

// ----- src/sgpg_ifs.sv -----
// Stream interfaces for the pixel coordinate input and the intensity output.
interface sgpg_pix_if;
  logic                            valid;
  logic                            ready;
  logic [sgpg_pkg::CoordW-1:0]     row;
  logic [sgpg_pkg::CoordW-1:0]     col;

  modport source (output valid, output row, output col, input ready);
  modport sink (input valid, input row, input col, output ready);
endinterface

interface sgpg_int_if;
  logic                          valid;
  logic                          ready;
  logic [sgpg_pkg::OutW-1:0]     intensity;

  modport source (output valid, output intensity, input ready);
  modport sink (input valid, input intensity, output ready);
endinterface

// ----- src/sgpg_lane.sv -----
// One grating lane: coordinate to phase index to signed sine, seven register stages.
module sgpg_lane #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic [sgpg_pkg::LaneStages-1:0]   en_i,
  input  logic [sgpg_pkg::CoordW-1:0]       pos_i,
  input  logic [sgpg_pkg::CfgW-1:0]         freq_i,
  input  logic [sgpg_pkg::CfgW-1:0]         stretch_i,
  output logic [sgpg_pkg::SinW-1:0]         sine_o,
  output logic                              neg_o
);

  localparam int QD    = SINE_TABLE_DEPTH / 4;
  localparam int D     = 4 * QD;
  localparam int IW    = $clog2(QD + 1);
  localparam int PW    = $clog2(D + 1);
  localparam int PMax  = sgpg_pkg::BasePeriod + 2 ** sgpg_pkg::CfgW - 1;
  localparam int PerW  = $clog2(PMax + 1);
  localparam int XW    = sgpg_pkg::CoordW + sgpg_pkg::CfgW;
  localparam int QmW   = $clog2((2 ** XW - 1) / sgpg_pkg::BasePeriod + 1);
  localparam int NMax  = (PMax - 1) * D + PMax / 2;
  localparam int S     = $clog2(NMax + 1);
  localparam int RW    = S - $clog2(sgpg_pkg::BasePeriod) + 1;

  // Quarter-wave sine entry in Q15, from a truncated Q30 Taylor series.
  function automatic logic [sgpg_pkg::SinW-1:0] sine_q15(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    int                 n;
    x    = (64'd1686629713 * 64'(k) + 64'(QD / 2)) / 64'(QD);
    term = x;
    sum  = $signed(x);
    for (n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = ($unsigned(sum) + 64'd16384) >> 15;
    if (r > 64'(sgpg_pkg::OneQ15)) begin
      r = 64'(sgpg_pkg::OneQ15);
    end
    return sgpg_pkg::SinW'(r);
  endfunction

  // Constant quarter-wave table and per-period reciprocals.
  logic [sgpg_pkg::SinW-1:0] rom [QD+1];
  logic [RW-1:0]             recip [2**sgpg_pkg::CfgW];

  for (genvar k = 0; k <= QD; k++) begin : g_rom
    assign rom[k] = sine_q15(k);
  end

  for (genvar s = 0; s < 2 ** sgpg_pkg::CfgW; s++) begin : g_recip
    localparam longint unsigned RecipVal = (longint'(1) << S) / (sgpg_pkg::BasePeriod + s);
    assign recip[s] = RW'(RecipVal);
  end

  logic [PerW-1:0] period;
  logic [RW-1:0]   r_cur;

  assign period = PerW'(sgpg_pkg::BasePeriod) + PerW'(stretch_i);
  assign r_cur  = recip[stretch_i];

  // Pipeline registers.
  logic [XW-1:0]             x1_q, x2_q;
  logic [QmW-1:0]            qm2_q;
  logic [PerW-1:0]           m3_q;
  logic [S-1:0]              n4_q, n5_q;
  logic [PW-1:0]             q5_q;
  logic [IW-1:0]             idx6_q;
  logic                      neg6_q, neg7_q;
  logic [sgpg_pkg::SinW-1:0] sine7_q;

  // Next values of each stage.
  logic [XW-1:0]    x1_d;
  logic [XW+RW-1:0] prod2;
  logic [QmW-1:0]   qm2_d;
  logic [XW-1:0]    t3;
  logic [PerW-1:0]  m3_d;
  logic [S-1:0]     n4_d;
  logic [S+RW-1:0]  prod5;
  logic [PW-1:0]    q5_d;
  logic [S-1:0]     rem6;
  logic [PW-1:0]    p6;
  logic [PW-1:0]    base6;
  logic [1:0]       quad6;
  logic [IW-1:0]    r6;
  logic [IW-1:0]    idx6_d;

  always_comb begin
    // Product of position and frequency.
    x1_d  = XW'(pos_i) * XW'(freq_i);
    // Estimated quotient by the period, low by at most one.
    prod2 = (XW+RW)'(x1_q) * (XW+RW)'(r_cur);
    qm2_d = QmW'(prod2 >> S);
    // Remainder with a single correction step.
    t3    = x2_q - XW'(qm2_q) * XW'(period);
    m3_d  = (t3 >= XW'(period)) ? PerW'(t3 - XW'(period)) : PerW'(t3);
    // Scaled phase numerator, rounded to nearest.
    n4_d  = S'(m3_q) * S'(D) + S'(period >> 1);
    // Phase index estimate.
    prod5 = (S+RW)'(n4_q) * (S+RW)'(r_cur);
    q5_d  = PW'(prod5 >> S);
    // Correct the index, wrap, and fold into the quarter wave.
    rem6  = n5_q - S'(q5_q) * S'(period);
    p6    = (rem6 >= S'(period)) ? q5_q + PW'(1) : q5_q;
    if (p6 >= PW'(D)) begin
      p6 = '0;
    end
    if (p6 >= PW'(3 * QD)) begin
      quad6 = 2'd3;
      base6 = PW'(3 * QD);
    end else if (p6 >= PW'(2 * QD)) begin
      quad6 = 2'd2;
      base6 = PW'(2 * QD);
    end else if (p6 >= PW'(QD)) begin
      quad6 = 2'd1;
      base6 = PW'(QD);
    end else begin
      quad6 = 2'd0;
      base6 = '0;
    end
    r6     = IW'(p6 - base6);
    idx6_d = quad6[0] ? IW'(QD) - r6 : r6;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x1_q <= x1_d;
    end
    if (en_i[1]) begin
      x2_q  <= x1_q;
      qm2_q <= qm2_d;
    end
    if (en_i[2]) begin
      m3_q <= m3_d;
    end
    if (en_i[3]) begin
      n4_q <= n4_d;
    end
    if (en_i[4]) begin
      n5_q <= n4_q;
      q5_q <= q5_d;
    end
    if (en_i[5]) begin
      idx6_q <= idx6_d;
      neg6_q <= quad6[1];
    end
    if (en_i[6]) begin
      sine7_q <= rom[idx6_q];
      neg7_q  <= neg6_q;
    end
  end

  assign sine_o = sine7_q;
  assign neg_o  = neg7_q;

endmodule

// ----- src/sine_grating_pixel_generator_core.sv -----
// An accepted pixel passes through the ten register stages before its intensity comes out.
// Throughput: one pixel per clock while the output is not stalled; each register stage moves
// on its own as soon as the stage after it has room, so bubbles close up under back-pressure.
// The sine comes from a constant quarter-wave table read in a registered stage.
// Reset clears all four configuration registers to 0 and empties the pipeline.
module sine_grating_pixel_generator_core #(
  parameter int IMG_SIZE         = 256,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sgpg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sgpg_pkg::CfgW-1:0]        cfg_data_i,
  sgpg_pix_if.sink                         pix_i,
  sgpg_int_if.source                       res_o
);

  localparam int NS = sgpg_pkg::NumStages;
  localparam int LS = sgpg_pkg::LaneStages;

  // Configuration registers.
  logic [sgpg_pkg::CfgW-1:0] amp_q, hfreq_q, vfreq_q, stretch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q     <= '0;
      hfreq_q   <= '0;
      vfreq_q   <= '0;
      stretch_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sgpg_pkg::CFG_AMPLITUDE: amp_q     <= cfg_data_i;
        sgpg_pkg::CFG_HFREQ:     hfreq_q   <= cfg_data_i;
        sgpg_pkg::CFG_VFREQ:     vfreq_q   <= cfg_data_i;
        sgpg_pkg::CFG_STRETCH:   stretch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Per-stage valid bits and load enables; a stage loads when it is empty or drains.
  logic [NS-1:0] valid_q;
  logic [NS-1:0] en;
  logic [NS-1:0] oob_q;

  always_comb begin
    en[NS-1] = !valid_q[NS-1] || res_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= (k == 0) ? pix_i.valid : valid_q[k-1];
        end
      end
    end
  end

  // Out-of-image flag travels alongside the data.
  logic oob_d;

  assign oob_d = (32'(pix_i.row) >= 32'(IMG_SIZE)) || (32'(pix_i.col) >= 32'(IMG_SIZE));

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        oob_q[k] <= (k == 0) ? oob_d : oob_q[k-1];
      end
    end
  end

  // Horizontal and vertical grating lanes.
  logic [sgpg_pkg::SinW-1:0] sin_h, sin_v;
  logic                      neg_h, neg_v;

  sgpg_lane #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lane_h (
    .clk_i     (clk_i),
    .en_i      (en[LS-1:0]),
    .pos_i     (pix_i.col),
    .freq_i    (hfreq_q),
    .stretch_i (stretch_q),
    .sine_o    (sin_h),
    .neg_o     (neg_h)
  );

  sgpg_lane #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lane_v (
    .clk_i     (clk_i),
    .en_i      (en[LS-1:0]),
    .pos_i     (pix_i.row),
    .freq_i    (vfreq_q),
    .stretch_i (stretch_q),
    .sine_o    (sin_v),
    .neg_o     (neg_v)
  );

  // Stage 8: sum of the signed sines scaled by the amplitude step.
  logic signed [16:0] sh, sv;
  logic signed [17:0] ssum;
  logic signed [22:0] amp_s;
  logic signed [22:0] n_d, n_q;

  always_comb begin
    sh    = neg_h ? -$signed({1'b0, sin_h}) : $signed({1'b0, sin_h});
    sv    = neg_v ? -$signed({1'b0, sin_v}) : $signed({1'b0, sin_v});
    ssum  = 18'(sh) + 18'(sv);
    amp_s = $signed({19'b0, amp_q});
    n_d   = amp_s * 23'(ssum);
  end

  always_ff @(posedge clk_i) begin
    if (en[LS]) begin
      n_q <= n_d;
    end
  end

  // Stage 9: magnitude, rounding bias, divide by 8 and estimate the divide by 5.
  logic [21:0] abs_n;
  logic [21:0] biased;
  logic [16:0] b9_d, b9_q;
  logic [34:0] prod9;
  logic [14:0] q9_d, q9_q;
  logic        neg9_q;

  always_comb begin
    abs_n  = n_q[22] ? 22'(-n_q) : 22'(n_q);
    biased = abs_n + 22'(sgpg_pkg::RoundBias);
    b9_d   = 17'(biased >> sgpg_pkg::AmpDivShift);
    prod9  = 35'(b9_d) * 35'(sgpg_pkg::DivFiveRecip);
    q9_d   = 15'(prod9 >> sgpg_pkg::DivFiveShift);
  end

  always_ff @(posedge clk_i) begin
    if (en[LS+1]) begin
      b9_q   <= b9_d;
      q9_q   <= q9_d;
      neg9_q <= n_q[22];
    end
  end

  // Stage 10: correct the quotient, offset around mid gray and saturate; out-of-image pixels give 0.
  logic [16:0] r10;
  logic [14:0] mag;
  logic [sgpg_pkg::OutW-1:0] intensity_d, intensity_q;

  always_comb begin
    r10 = b9_q - 17'(q9_q) * 17'(sgpg_pkg::DivFive);
    mag = (r10 >= 17'(sgpg_pkg::DivFive)) ? q9_q + 15'd1 : q9_q;
    if (neg9_q) begin
      intensity_d = (16'(mag) > 16'(sgpg_pkg::OneHalfQ15)) ? '0
                    : 16'(sgpg_pkg::OneHalfQ15) - 16'(mag);
    end else begin
      intensity_d = (16'(mag) > 16'(sgpg_pkg::OneHalfQ15)) ? 16'(sgpg_pkg::OneQ15)
                    : 16'(sgpg_pkg::OneHalfQ15) + 16'(mag);
    end
    if (oob_q[NS-2]) begin
      intensity_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      intensity_q <= intensity_d;
    end
  end

  assign res_o.valid     = valid_q[NS-1];
  assign res_o.intensity = intensity_q;

`ifndef NO_ASSERTIONS
  // An accepted transaction always lands in the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> valid_q[0])
    else $error("accepted transaction did not enter the pipeline");

  // A held stage 8 keeps both its valid bit and its data.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[LS] && !en[LS]) |=> (valid_q[LS] && $stable(n_q)))
    else $error("stalled stage lost or changed its data");

  // Intensity never exceeds full scale.
  a_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.intensity <= 16'(sgpg_pkg::OneQ15)))
    else $error("intensity above full scale");

  // Pixels outside the image come out black.
  a_oob_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && oob_q[NS-1]) |-> (res_o.intensity == '0))
    else $error("out-of-image pixel is not black");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the sine grating pixel generator core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sgpg_pkg::*;

  localparam int ImgSize      = 256;
  localparam int TableDepth   = 1024;
  localparam int QuarterDepth = TableDepth / 4;
  localparam int MaxGap       = 19;
  localparam int LongHold     = 80;
  localparam int SettleCycles = 20;

  // Holds the predicted intensities and compares them with what the core returns.
  class grating_scoreboard;
    logic [OutW-1:0] expected_intensity[$];
    int unsigned     sine_rom[QuarterDepth+1];
    logic [CfgW-1:0] amplitude;
    logic [CfgW-1:0] h_freq;
    logic [CfgW-1:0] v_freq;
    logic [CfgW-1:0] stretch;
    int              failures;

    function new();
      amplitude = '0;
      h_freq    = '0;
      v_freq    = '0;
      stretch   = '0;
      failures  = 0;
      for (int k = 0; k <= QuarterDepth; k++) begin
        sine_rom[k] = quarter_sine(k);
      end
    endfunction

    // One quarter-wave entry: integer Taylor series in Q30, rounded to Q15.
    function int unsigned quarter_sine(int unsigned k);
      longint unsigned x;
      longint unsigned term;
      longint          sum;
      longint unsigned rounded;
      x    = (64'd1686629713 * longint'(k) + QuarterDepth / 2) / QuarterDepth;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      rounded = (longint'(sum) + (1 << 14)) >> 15;
      if (rounded > OneQ15) begin
        rounded = OneQ15;
      end
      return int'(rounded);
    endfunction

    // Signed Q15 sine of one grating at a position along its axis.
    function int grating_sine(int unsigned pos, int unsigned freq);
      int unsigned period;
      int unsigned phase;
      int unsigned index;
      int unsigned quadrant;
      int unsigned offset;
      int unsigned entry;
      period = BasePeriod + stretch;
      phase  = (pos * freq) % period;
      index  = (phase * TableDepth + period / 2) / period;
      if (index >= TableDepth) begin
        index = 0;
      end
      quadrant = index / QuarterDepth;
      offset   = index % QuarterDepth;
      entry    = (quadrant % 2 == 1) ? sine_rom[QuarterDepth - offset] : sine_rom[offset];
      return (quadrant >= 2) ? -int'(entry) : int'(entry);
    endfunction

    function logic [OutW-1:0] predict_intensity(logic [CoordW-1:0] row,
                                                logic [CoordW-1:0] col);
      int sum_n;
      int mag;
      int level;
      if (row >= ImgSize || col >= ImgSize) begin
        return '0;
      end
      sum_n = int'(amplitude) * (grating_sine(col, h_freq) + grating_sine(row, v_freq));
      mag   = ((sum_n < 0 ? -sum_n : sum_n) + RoundBias) / 40;
      level = OneHalfQ15 + (sum_n < 0 ? -mag : mag);
      if (level < 0) begin
        level = 0;
      end
      if (level > OneQ15) begin
        level = OneQ15;
      end
      return level[OutW-1:0];
    endfunction

    function void set_register(cfg_reg_e idx, logic [CfgW-1:0] value);
      case (idx)
        CFG_AMPLITUDE: amplitude = value;
        CFG_HFREQ:     h_freq    = value;
        CFG_VFREQ:     v_freq    = value;
        CFG_STRETCH:   stretch   = value;
        default:       ;
      endcase
    endfunction

    function void note_pixel(logic [CoordW-1:0] row, logic [CoordW-1:0] col);
      expected_intensity.push_back(predict_intensity(row, col));
    endfunction

    function void check_intensity(logic [OutW-1:0] actual);
      logic [OutW-1:0] predicted;
      if (expected_intensity.size() == 0) begin
        if (failures < 10) begin
          $display("unexpected intensity %0d with no pixel outstanding", actual);
        end
        failures++;
        return;
      end
      predicted = expected_intensity.pop_front();
      if (actual !== predicted) begin
        if (failures < 10) begin
          $display("intensity mismatch: expected %0d, got %0d", predicted, actual);
        end
        failures++;
      end
    endfunction

    function int pending();
      return expected_intensity.size();
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  cfg_reg_e        cfg_idx;
  logic [CfgW-1:0] cfg_data;

  sgpg_pix_if pix_if();
  sgpg_int_if res_if();

  grating_scoreboard sb;
  int idle_level;
  int sink_hold_cycles;

  sine_grating_pixel_generator_core #(
    .IMG_SIZE        (ImgSize),
    .SINE_TABLE_DEPTH(TableDepth)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .pix_i     (pix_if),
    .res_o     (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Gap before the next transaction: none, always drawn, or drawn now and then.
  function automatic int draw_gap();
    case (idle_level)
      1:       return $urandom_range(0, MaxGap);
      2:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MaxGap) : 0;
      default: return 0;
    endcase
  endfunction

  // Random coordinate with extra weight on the edges of the image.
  function automatic logic [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CoordW'($urandom_range(0, 255));
    endcase
  endfunction

  // Record every accepted pixel and check every accepted intensity.
  always @(posedge clk_i) begin
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      sb.note_pixel(pix_if.row, pix_if.col);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_intensity(res_if.intensity);
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin : result_sink
    int stall;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  task automatic send_pixel(input logic [CoordW-1:0] row, input logic [CoordW-1:0] col);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.row   <= row;
    pix_if.col   <= col;
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel(pick_coord(), pick_coord());
    end
  endtask

  // Stop offering pixels and wait until every expected intensity has arrived.
  // The first edge lets the monitor record the last accepted pixel.
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write all four registers on consecutive cycles while the core is idle.
  task automatic program_regs(input logic [CfgW-1:0] amp, input logic [CfgW-1:0] hf,
                              input logic [CfgW-1:0] vf, input logic [CfgW-1:0] st);
    cfg_reg_e        order[4];
    logic [CfgW-1:0] value[4];
    order = '{CFG_AMPLITUDE, CFG_HFREQ, CFG_VFREQ, CFG_STRETCH};
    value = '{amp, hf, vf, st};
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_idx  <= order[i];
      cfg_data <= value[i];
      sb.set_register(order[i], value[i]);
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Timeout guard.
  initial begin
    #2_000_000;
    $display("sine_grating_pixel_generator_core verification failed");
    $finish;
  end

  // Stimulus: directed pixels first, then random phases over many register settings.
  initial begin : stimulus
    logic [CfgW-1:0] phase_cfg[8][4];
    sb               = new();
    idle_level       = 0;
    sink_hold_cycles = 0;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_AMPLITUDE;
    cfg_data         = '0;
    pix_if.valid     = 1'b0;
    pix_if.row       = '0;
    pix_if.col       = '0;
    phase_cfg = '{'{4'd10, 4'd10, 4'd10, 4'd10}, '{4'd0, 4'd15, 4'd15, 4'd15},
                  '{4'd15, 4'd0, 4'd0, 4'd0}, '{4'd5, 4'd3, 4'd7, 4'd0},
                  '{4'd15, 4'd10, 4'd0, 4'd15}, '{4'd1, 4'd1, 4'd2, 4'd9},
                  '{4'd0, 4'd0, 4'd0, 4'd0}, '{4'd15, 4'd15, 4'd15, 4'd15}};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers still at reset: every pixel is mid gray.
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd77, 8'd200);
    wait_drained();

    // One cycle per period: walk both gratings through all four quadrants.
    program_regs(4'd10, 4'd1, 4'd1, 4'd0);
    idle_level = 1;
    send_pixel(8'd0, 8'd64);
    send_pixel(8'd64, 8'd64);
    send_pixel(8'd128, 8'd128);
    send_pixel(8'd192, 8'd192);
    send_pixel(8'd192, 8'd64);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd32, 8'd224);
    send_pixel(8'd170, 8'd85);
    send_pixel(8'd127, 8'd129);
    wait_drained();

    // All registers at their widest values: the sum saturates at both ends.
    program_regs(4'd15, 4'd15, 4'd15, 4'd15);
    idle_level = 2;
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd4, 8'd4);
    send_pixel(8'd13, 8'd13);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd86, 8'd86);
    send_pixel(8'd128, 8'd1);
    wait_drained();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 11; ph++) begin
      if (ph < 8) begin
        program_regs(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2], phase_cfg[ph][3]);
      end else begin
        program_regs(CfgW'($urandom_range(0, 15)), CfgW'($urandom_range(0, 15)),
                     CfgW'($urandom_range(0, 15)), CfgW'($urandom_range(0, 15)));
      end
      idle_level = ph % 3;
      if (ph == 3) begin
        // Long receiver hold-off while pixels keep coming back to back.
        idle_level       = 0;
        sink_hold_cycles = LongHold;
        send_random(40);
        wait_drained();
        idle_level = 1;
      end
      send_random(40);
      wait_drained();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending() != 0 && sb.failures < 10) begin
      $display("%0d expected intensities never arrived", sb.pending());
    end
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("sine_grating_pixel_generator_core verification clean");
    end else begin
      $display("sine_grating_pixel_generator_core verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/sgpg_pkg.sv
src/sgpg_ifs.sv
src/sgpg_lane.sv
src/sine_grating_pixel_generator_core.sv
verif/tb_top.sv
